// ===== hw/rtl/lob_pkg.sv =====
// Package for the limit order book matcher: sizes, codes, cell command
// and candidate types shared by the cells and the top level.
// No dependencies.
package lob_pkg;

  localparam int SIDE_DEPTH = 32;
  localparam int SLOT_BITS  = $clog2(SIDE_DEPTH);
  localparam int PRICE_BITS = 16;
  localparam int CNT_BITS   = $clog2(SIDE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LIMIT  = 2'd0,
    OP_MARKET = 2'd1,
    OP_CANCEL = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_CLEAR,
    CMD_SUB
  } cmd_op_t;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_MATCH,
    MODE_MKT_BUY,
    MODE_MKT_SELL
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_TRADE_OUT,
    S_DONE_OUT
  } state_t;

  // Command broadcast to every cell of one side
  typedef struct packed {
    cmd_op_t                 op;
    logic [SLOT_BITS-1:0]    slot;
    logic [PRICE_BITS-1:0]   price;
    logic [31:0]             qty;
    logic [31:0]             ident;
    logic [31:0]             arrival;
  } cell_cmd_t;

  // Running best order that travels down the chain
  typedef struct packed {
    logic                    found;
    logic [PRICE_BITS-1:0]   price;
    logic [31:0]             age;
    logic [SLOT_BITS-1:0]    slot;
    logic [31:0]             remaining;
    logic [31:0]             ident;
  } cand_t;

endpackage

// ===== hw/rtl/lob_in_if.sv =====
// Input channel of the order book: valid/ready plus one order transaction.
// Depends on nothing.
interface lob_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        side;
  logic [15:0] limit_price;
  logic [31:0] quantity;
  logic [31:0] order_ref;

  modport source (output valid, opcode, side, limit_price, quantity, order_ref,
                  input ready);
  modport sink   (input valid, opcode, side, limit_price, quantity, order_ref,
                  output ready);
endinterface

// ===== hw/rtl/lob_out_if.sv =====
// Output channel of the order book: valid/ready plus one trade or done report.
// Depends on nothing.
interface lob_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] buyer_id;
  logic [31:0] seller_id;
  logic [15:0] fill_price;
  logic [31:0] trade_qty;
  logic [31:0] trade_number;
  logic [1:0]  status;
  logic [15:0] best_bid;
  logic [15:0] best_ask;
  logic        last;

  modport source (output valid, kind, buyer_id, seller_id, fill_price, trade_qty,
                  trade_number, status, best_bid, best_ask, last,
                  input ready);
  modport sink   (input valid, kind, buyer_id, seller_id, fill_price, trade_qty,
                  trade_number, status, best_bid, best_ask, last,
                  output ready);
endinterface

// ===== hw/rtl/lob_cell.sv =====
// One order slot of a book side; compares itself against the candidate
// from its left neighbor and registers the better one. Uses lob_pkg.
module lob_cell
  import lob_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 want_high,
  input  logic [SLOT_BITS-1:0] my_slot,
  input  logic [31:0]          now,
  input  cell_cmd_t            cmd,
  input  cand_t                cand_in,
  output cand_t                cand_out,
  output logic                 valid,
  output logic [31:0]          ident
);

  logic [PRICE_BITS-1:0] price;
  logic [31:0]           remaining;
  logic [31:0]           arrival;
  logic [31:0]           age;
  logic [31:0]           rem_sub;
  logic                  hit;
  logic                  better;
  cand_t                 mine;

  assign hit     = (cmd.slot == my_slot);
  assign age     = now - arrival;
  assign rem_sub = remaining - cmd.qty;

  // Strictly better than the candidate: price first, then older arrival
  always_comb begin
    mine.found     = 1'b1;
    mine.price     = price;
    mine.age       = age;
    mine.slot      = my_slot;
    mine.remaining = remaining;
    mine.ident     = ident;
    better = valid && (!cand_in.found ||
                       (want_high ? (price > cand_in.price) : (price < cand_in.price)) ||
                       ((price == cand_in.price) && (age > cand_in.age)));
  end

  // Advance the candidate one cell
  always_ff @(posedge clk) begin
    cand_out <= better ? mine : cand_in;
  end

  // Apply write, clear and fill commands
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (hit) begin
      unique case (cmd.op)
        CMD_WRITE: valid <= 1'b1;
        CMD_CLEAR: valid <= 1'b0;
        CMD_SUB:   if (rem_sub == 32'd0) valid <= 1'b0;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (hit && cmd.op == CMD_WRITE) begin
      price     <= cmd.price;
      remaining <= cmd.qty;
      ident     <= cmd.ident;
      arrival   <= cmd.arrival;
    end else if (hit && cmd.op == CMD_SUB) begin
      remaining <= rem_sub;
    end
  end

endmodule

// ===== hw/rtl/limit_order_book_matcher.sv =====
// Price-time priority limit order book: two chains of SIDE_DEPTH cells,
// one per side, and a sequencer. Uses lob_pkg, lob_cell, lob_in_if, lob_out_if.
// Each best-order selection is a pass down the cell chains followed by a decide
// state; an item takes one selection per fill plus one more. One item is in
// work at a time.
// Reset (synchronous, rst high) empties both sides and zeroes both counters.
module limit_order_book_matcher
  import lob_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lob_in_if.sink    req,
  lob_out_if.source rsp
);

  state_t state, state_next;
  mode_t  mode;
  logic [CNT_BITS-1:0] scan_cnt;
  logic [31:0] arrival_counter;
  logic [31:0] trade_counter;
  logic [31:0] rem;
  logic [31:0] id_q;
  status_t     status_q;

  cell_cmd_t bid_cmd, ask_cmd;
  cand_t     bid_chain [SIDE_DEPTH+1];
  cand_t     ask_chain [SIDE_DEPTH+1];
  logic [SIDE_DEPTH-1:0] bid_valid, ask_valid;
  logic [31:0] bid_ident [SIDE_DEPTH];
  logic [31:0] ask_ident [SIDE_DEPTH];

  assign bid_chain[0] = '0;
  assign ask_chain[0] = '0;

  for (genvar g = 0; g < SIDE_DEPTH; g++) begin : g_cells
    lob_cell u_bid (
      .clk(clk), .rst(rst), .want_high(1'b1), .my_slot(SLOT_BITS'(g)),
      .now(arrival_counter), .cmd(bid_cmd), .cand_in(bid_chain[g]),
      .cand_out(bid_chain[g+1]), .valid(bid_valid[g]), .ident(bid_ident[g])
    );
    lob_cell u_ask (
      .clk(clk), .rst(rst), .want_high(1'b0), .my_slot(SLOT_BITS'(g)),
      .now(arrival_counter), .cmd(ask_cmd), .cand_in(ask_chain[g]),
      .cand_out(ask_chain[g+1]), .valid(ask_valid[g]), .ident(ask_ident[g])
    );
  end

  cand_t b, a;
  assign b = bid_chain[SIDE_DEPTH];
  assign a = ask_chain[SIDE_DEPTH];

  // Lowest free slot and lowest id match per side
  logic                 bid_free_ok, ask_free_ok, bid_hit_ok, ask_hit_ok;
  logic [SLOT_BITS-1:0] bid_free, ask_free, bid_hit, ask_hit;
  always_comb begin
    bid_free_ok = 1'b0; ask_free_ok = 1'b0; bid_hit_ok = 1'b0; ask_hit_ok = 1'b0;
    bid_free = '0; ask_free = '0; bid_hit = '0; ask_hit = '0;
    for (int i = SIDE_DEPTH - 1; i >= 0; i--) begin
      if (!bid_valid[i]) begin bid_free_ok = 1'b1; bid_free = SLOT_BITS'(i); end
      if (!ask_valid[i]) begin ask_free_ok = 1'b1; ask_free = SLOT_BITS'(i); end
      if (bid_valid[i] && bid_ident[i] == req.order_ref) begin
        bid_hit_ok = 1'b1; bid_hit = SLOT_BITS'(i);
      end
      if (ask_valid[i] && ask_ident[i] == req.order_ref) begin
        ask_hit_ok = 1'b1; ask_hit = SLOT_BITS'(i);
      end
    end
  end

  logic accept;
  assign accept = req.valid && req.ready;

  // Trade decision from the two chain tails
  logic        trade_go, hit_bid, hit_ask;
  logic [31:0] fill, buyer, seller;
  logic [PRICE_BITS-1:0] tprice;
  always_comb begin
    trade_go = 1'b0; hit_bid = 1'b0; hit_ask = 1'b0;
    fill = '0; buyer = '0; seller = '0; tprice = '0;
    unique case (mode)
      MODE_MATCH: begin
        trade_go = b.found && a.found && (b.price >= a.price);
        fill     = (b.remaining < a.remaining) ? b.remaining : a.remaining;
        buyer = b.ident; seller = a.ident; tprice = a.price;
        hit_bid = 1'b1; hit_ask = 1'b1;
      end
      MODE_MKT_BUY: begin
        trade_go = (rem != 32'd0) && a.found;
        fill     = (rem < a.remaining) ? rem : a.remaining;
        buyer = id_q; seller = a.ident; tprice = a.price;
        hit_ask = 1'b1;
      end
      MODE_MKT_SELL: begin
        trade_go = (rem != 32'd0) && b.found;
        fill     = (rem < b.remaining) ? rem : b.remaining;
        buyer = b.ident; seller = id_q; tprice = b.price;
        hit_bid = 1'b1;
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (accept) state_next = S_SCAN;
      S_SCAN:      if (scan_cnt == CNT_BITS'(SIDE_DEPTH - 1)) state_next = S_DECIDE;
      S_DECIDE:    state_next = trade_go ? S_TRADE_OUT : S_DONE_OUT;
      S_TRADE_OUT: if (rsp.ready) state_next = S_SCAN;
      S_DONE_OUT:  if (rsp.ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Outputs and cell commands
  always_comb begin
    req.ready = (state == S_IDLE);
    rsp.valid = (state == S_TRADE_OUT) || (state == S_DONE_OUT);
    bid_cmd = '0;
    ask_cmd = '0;
    bid_cmd.op = CMD_NONE;
    ask_cmd.op = CMD_NONE;
    if (accept) begin
      if (opcode_t'(req.opcode) == OP_LIMIT && req.quantity != 32'd0) begin
        bid_cmd.price = req.limit_price[PRICE_BITS-1:0];
        bid_cmd.qty = req.quantity; bid_cmd.ident = req.order_ref;
        bid_cmd.arrival = arrival_counter;
        ask_cmd = bid_cmd;
        bid_cmd.slot = bid_free;
        ask_cmd.slot = ask_free;
        if (!req.side && bid_free_ok) bid_cmd.op = CMD_WRITE;
        if (req.side && ask_free_ok)  ask_cmd.op = CMD_WRITE;
      end else if (opcode_t'(req.opcode) == OP_CANCEL) begin
        bid_cmd.slot = bid_hit;
        ask_cmd.slot = ask_hit;
        if (bid_hit_ok) bid_cmd.op = CMD_CLEAR;
        else if (ask_hit_ok) ask_cmd.op = CMD_CLEAR;
      end
    end else if (state == S_DECIDE && trade_go) begin
      bid_cmd.slot = b.slot; bid_cmd.qty = fill;
      ask_cmd.slot = a.slot; ask_cmd.qty = fill;
      if (hit_bid) bid_cmd.op = CMD_SUB;
      if (hit_ask) ask_cmd.op = CMD_SUB;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      scan_cnt <= '0;
      arrival_counter <= '0;
      trade_counter <= '0;
      mode <= MODE_NONE;
      status_q <= ST_OK;
    end else begin
      state <= state_next;
      if (state_next == S_SCAN && state != S_SCAN) scan_cnt <= '0;
      else if (state == S_SCAN) scan_cnt <= scan_cnt + 1'b1;
      if (accept) begin
        unique case (opcode_t'(req.opcode))
          OP_LIMIT: begin
            if (req.quantity == 32'd0) begin
              mode <= MODE_NONE;
              status_q <= ST_OK;
            end else if (req.side ? ask_free_ok : bid_free_ok) begin
              mode <= MODE_MATCH;
              status_q <= ST_OK;
              arrival_counter <= arrival_counter + 32'd1;
            end else begin
              mode <= MODE_NONE;
              status_q <= ST_FULL;
            end
          end
          OP_MARKET: begin
            if (req.quantity != 32'd0)
              mode <= req.side ? MODE_MKT_SELL : MODE_MKT_BUY;
            else
              mode <= MODE_NONE;
            status_q <= ST_OK;
          end
          OP_CANCEL: begin
            mode <= MODE_NONE;
            status_q <= (!bid_hit_ok && !ask_hit_ok) ? ST_NOT_FOUND : ST_OK;
          end
          default: begin
            mode <= MODE_NONE;
            status_q <= ST_OK;
          end
        endcase
      end
      if (state == S_DECIDE && trade_go) trade_counter <= trade_counter + 32'd1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rem  <= req.quantity;
      id_q <= req.order_ref;
    end
    if (state == S_DECIDE) begin
      if (trade_go) begin
        rem <= rem - fill;
        rsp.kind <= 1'b0; rsp.buyer_id <= buyer; rsp.seller_id <= seller;
        rsp.fill_price <= 16'(tprice); rsp.trade_qty <= fill;
        rsp.trade_number <= trade_counter; rsp.status <= ST_OK;
        rsp.best_bid <= '0; rsp.best_ask <= '0; rsp.last <= 1'b0;
      end else begin
        rsp.kind <= 1'b1; rsp.buyer_id <= '0; rsp.seller_id <= '0;
        rsp.fill_price <= '0; rsp.trade_qty <= '0; rsp.trade_number <= '0;
        rsp.status <= status_q;
        rsp.best_bid <= b.found ? 16'(b.price) : 16'd0;
        rsp.best_ask <= a.found ? 16'(a.price) : 16'd0;
        rsp.last <= 1'b1;
      end
    end
  end

  // Checks
  a_accept_scans: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_SCAN) else $error("accept did not start a scan");
  a_decide_after_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE |-> $past(state) == S_SCAN) else $error("decide without scan");
  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.kind |-> rsp.trade_qty != 32'd0) else $error("zero fill");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_cnt < CNT_BITS'(SIDE_DEPTH)) else $error("scan overrun");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for limit_order_book_matcher: a scoreboard class keeps
// its own copy of the book and predicts every trade and done report.
// Depends on lob_pkg, lob_in_if, lob_out_if and the matcher RTL.
module testbench;
  import lob_pkg::*;

  localparam int  CLK_HALF     = 5;
  localparam int  CYCLE_LIMIT  = 3000000;
  localparam int  RANDOM_ITEMS = 420;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  HOLD_CYCLES  = 600;
  localparam bit  KIND_TRADE   = 1'b0;
  localparam bit  KIND_DONE    = 1'b1;
  localparam bit  SIDE_BUY     = 1'b0;
  localparam bit  SIDE_SELL    = 1'b1;

  typedef struct packed {
    opcode_t     opcode;
    logic        side;
    logic [15:0] limit_price;
    logic [31:0] quantity;
    logic [31:0] order_ref;
  } order_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [15:0] fill_price;
    logic [31:0] trade_qty;
    logic [31:0] trade_number;
    logic [1:0]  status;
    logic [15:0] best_bid;
    logic [15:0] best_ask;
    logic        last;
  } report_t;

  // Book model and queue of pending reports
  class book_scoreboard;
    logic [15:0] price_q   [2][SIDE_DEPTH];
    logic [31:0] remain_q  [2][SIDE_DEPTH];
    logic [31:0] ident_q   [2][SIDE_DEPTH];
    logic [31:0] arrive_q  [2][SIDE_DEPTH];
    bit          live_q    [2][SIDE_DEPTH];
    logic [31:0] arrival_cnt;
    logic [31:0] trade_cnt;
    report_t     pending[$];
    int          errors;

    function void clear();
      foreach (live_q[s, i]) live_q[s][i] = 0;
      arrival_cnt = 0;
      trade_cnt   = 0;
      errors      = 0;
      pending.delete();
    endfunction

    // Best slot of one side (highest bid, lowest ask, older first), or -1
    function int best_slot(int s);
      int best;
      bit better;
      best = -1;
      for (int i = 0; i < SIDE_DEPTH; i++) begin
        if (!live_q[s][i]) continue;
        if (best < 0) begin
          best = i;
        end else begin
          better = (s == SIDE_BUY) ? (price_q[s][i] > price_q[s][best])
                                   : (price_q[s][i] < price_q[s][best]);
          if (!better && price_q[s][i] == price_q[s][best] &&
              (arrival_cnt - arrive_q[s][i]) > (arrival_cnt - arrive_q[s][best]))
            better = 1;
          if (better) best = i;
        end
      end
      return best;
    endfunction

    function void push_trade(logic [31:0] buyer, logic [31:0] seller,
                             logic [15:0] px, logic [31:0] qty);
      report_t r;
      r = '0;
      r.kind         = KIND_TRADE;
      r.buyer_id     = buyer;
      r.seller_id    = seller;
      r.fill_price   = px;
      r.trade_qty    = qty;
      r.trade_number = trade_cnt;
      pending.insert(pending.size(), r);
      trade_cnt++;
    endfunction

    // Apply one accepted transaction and queue its reports
    function void note_order(order_t o);
      int b, a, slot, s;
      logic [31:0] f, rem;
      status_t st;
      report_t r;
      st = ST_OK;
      s  = o.side;
      if (o.opcode == OP_LIMIT && o.quantity != 0) begin
        slot = -1;
        for (int i = SIDE_DEPTH - 1; i >= 0; i--) if (!live_q[s][i]) slot = i;
        if (slot < 0) begin
          st = ST_FULL;
        end else begin
          price_q[s][slot]  = o.limit_price;
          remain_q[s][slot] = o.quantity;
          ident_q[s][slot]  = o.order_ref;
          arrive_q[s][slot] = arrival_cnt;
          live_q[s][slot]   = 1;
          arrival_cnt++;
          // Match while the book crosses
          forever begin
            b = best_slot(SIDE_BUY);
            a = best_slot(SIDE_SELL);
            if (b < 0 || a < 0 || price_q[SIDE_BUY][b] < price_q[SIDE_SELL][a]) break;
            f = (remain_q[SIDE_BUY][b] < remain_q[SIDE_SELL][a]) ?
                remain_q[SIDE_BUY][b] : remain_q[SIDE_SELL][a];
            push_trade(ident_q[SIDE_BUY][b], ident_q[SIDE_SELL][a],
                       price_q[SIDE_SELL][a], f);
            remain_q[SIDE_BUY][b]  -= f;
            remain_q[SIDE_SELL][a] -= f;
            if (remain_q[SIDE_SELL][a] == 0) live_q[SIDE_SELL][a] = 0;
            if (remain_q[SIDE_BUY][b] == 0)  live_q[SIDE_BUY][b]  = 0;
          end
        end
      end else if (o.opcode == OP_MARKET && o.quantity != 0) begin
        // Sweep the opposite side at its resting prices
        rem = o.quantity;
        while (rem != 0) begin
          a = best_slot(1 - s);
          if (a < 0) break;
          f = (rem < remain_q[1-s][a]) ? rem : remain_q[1-s][a];
          if (s == SIDE_BUY)
            push_trade(o.order_ref, ident_q[1-s][a], price_q[1-s][a], f);
          else
            push_trade(ident_q[1-s][a], o.order_ref, price_q[1-s][a], f);
          remain_q[1-s][a] -= f;
          if (remain_q[1-s][a] == 0) live_q[1-s][a] = 0;
          rem -= f;
        end
      end else if (o.opcode == OP_CANCEL) begin
        st = ST_NOT_FOUND;
        for (int t = 0; t < 2 && st == ST_NOT_FOUND; t++)
          for (int i = 0; i < SIDE_DEPTH; i++)
            if (live_q[t][i] && ident_q[t][i] == o.order_ref) begin
              live_q[t][i] = 0;
              st = ST_OK;
              break;
            end
      end
      b = best_slot(SIDE_BUY);
      a = best_slot(SIDE_SELL);
      r = '0;
      r.kind     = KIND_DONE;
      r.status   = st;
      r.best_bid = (b < 0) ? 16'd0 : price_q[SIDE_BUY][b];
      r.best_ask = (a < 0) ? 16'd0 : price_q[SIDE_SELL][a];
      r.last     = 1'b1;
      pending.insert(pending.size(), r);
    endfunction

    function void report(string field, logic [31:0] e, logic [31:0] g);
      if (e !== g) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, e, g);
        errors++;
      end
    endfunction

    // Compare one accepted report with the oldest prediction
    function void check_report(report_t g);
      report_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected report, expected none, got %p", $time, g);
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      report("kind", e.kind, g.kind);
      report("buyer_id", e.buyer_id, g.buyer_id);
      report("seller_id", e.seller_id, g.seller_id);
      report("fill_price", e.fill_price, g.fill_price);
      report("trade_qty", e.trade_qty, g.trade_qty);
      report("trade_number", e.trade_number, g.trade_number);
      report("status", e.status, g.status);
      report("best_bid", e.best_bid, g.best_bid);
      report("best_ask", e.best_ask, g.best_ask);
      report("last", e.last, g.last);
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   burst_left;
  int   hold_req;
  int   hold_left;
  int   stall_mode;
  book_scoreboard book;

  lob_in_if  req ();
  lob_out_if rsp ();

  limit_order_book_matcher u_top (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always #CLK_HALF clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Check every accepted report
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      book.check_report('{rsp.kind, rsp.buyer_id, rsp.seller_id, rsp.fill_price,
                          rsp.trade_qty, rsp.trade_number, rsp.status,
                          rsp.best_bid, rsp.best_ask, rsp.last});
  end

  // Receiver back-pressure: shifting stall pattern plus a requested long hold-off
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 0;
    end
    if (cycles % 97 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      rsp.ready = 1'b0;
    end else begin
      case (stall_mode)
        0:       rsp.ready = 1'b1;
        1:       rsp.ready = ($urandom_range(0, 9) < 7);
        2:       rsp.ready = ($urandom_range(0, 3) == 0);
        default: rsp.ready = (cycles % 8) < 5;
      endcase
    end
  end

  // Offer one transaction, holding valid across bursts
  task automatic send_order(input order_t o);
    int gap;
    if (burst_left == 0) begin
      req.valid = 1'b0;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    req.valid       = 1'b1;
    req.opcode      = o.opcode;
    req.side        = o.side;
    req.limit_price = o.limit_price;
    req.quantity    = o.quantity;
    req.order_ref   = o.order_ref;
    do @(posedge clk); while (!req.ready);
    book.note_order(o);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_fields(input opcode_t op, input logic sd, input logic [15:0] px,
                             input logic [31:0] qty, input logic [31:0] id);
    send_order('{op, sd, px, qty, id});
  endtask

  task automatic wait_drained();
    req.valid  = 1'b0;
    burst_left = 0;
    while (book.pending.size() != 0) @(negedge clk);
  endtask

  // Random transaction: mostly live trading near one price band, some noise
  function automatic order_t random_order();
    order_t o;
    int pick;
    pick = $urandom_range(0, 99);
    o.side        = 1'($urandom_range(0, 1));
    o.limit_price = 16'd1000 + 16'($urandom_range(0, 24)) - 16'd12;
    o.quantity    = $urandom_range(1, 60);
    o.order_ref   = $urandom_range(0, 63);
    if (pick < 55) begin
      o.opcode = OP_LIMIT;
    end else if (pick < 70) begin
      o.opcode = OP_MARKET;
      if ($urandom_range(0, 7) == 0) o.quantity = $urandom;
    end else if (pick < 88) begin
      o.opcode = OP_CANCEL;
    end else begin
      o.opcode      = opcode_t'($urandom_range(0, 3));
      o.limit_price = 16'($urandom_range(0, 65535));
      o.quantity    = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom;
      o.order_ref   = $urandom;
    end
    return o;
  endfunction

  initial begin
    book = new();
    book.clear();
    clk        = 1'b0;
    rst        = 1'b1;
    cycles     = 0;
    burst_left = 0;
    hold_req   = 0;
    hold_left  = 0;
    stall_mode = 0;
    req.valid       = 1'b0;
    req.opcode      = OP_LIMIT;
    req.side        = SIDE_BUY;
    req.limit_price = '0;
    req.quantity    = '0;
    req.order_ref   = '0;
    rsp.ready       = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty book corners, zero quantity and the unused opcode
    send_fields(OP_CANCEL, SIDE_BUY, 16'd0, 32'd0, 32'hFFFF_FFFF);
    send_fields(OP_MARKET, SIDE_BUY, 16'd0, 32'd10, 32'd1);
    send_fields(OP_MARKET, SIDE_SELL, 16'hFFFF, 32'd10, 32'd2);
    send_fields(OP_LIMIT, SIDE_BUY, 16'd500, 32'd0, 32'd3);
    send_fields(OP_UNUSED, SIDE_SELL, 16'hFFFF, 32'hFFFF_FFFF, 32'd4);
    // Extreme prices and quantities, crossing at the ask price
    send_fields(OP_LIMIT, SIDE_BUY, 16'd0, 32'd1, 32'd10);
    send_fields(OP_LIMIT, SIDE_SELL, 16'hFFFF, 32'hFFFF_FFFF, 32'd11);
    send_fields(OP_LIMIT, SIDE_BUY, 16'hFFFF, 32'd5, 32'd12);
    send_fields(OP_MARKET, SIDE_SELL, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_fields(OP_MARKET, SIDE_BUY, 16'd0, 32'hFFFF_FFFF, 32'd13);
    // Duplicate ids: cancels take the bids first, then the ask, then miss
    send_fields(OP_LIMIT, SIDE_BUY, 16'd100, 32'd3, 32'd7);
    send_fields(OP_LIMIT, SIDE_SELL, 16'd300, 32'd3, 32'd7);
    send_fields(OP_LIMIT, SIDE_BUY, 16'd100, 32'd3, 32'd7);
    send_fields(OP_CANCEL, SIDE_SELL, 16'd0, 32'd0, 32'd7);
    send_fields(OP_CANCEL, SIDE_BUY, 16'd0, 32'd0, 32'd7);
    send_fields(OP_CANCEL, SIDE_BUY, 16'd0, 32'd0, 32'd7);
    send_fields(OP_CANCEL, SIDE_BUY, 16'd0, 32'd0, 32'd7);
    // Time priority at one ask level, market buy partly fills the second
    send_fields(OP_LIMIT, SIDE_SELL, 16'd200, 32'd2, 32'd20);
    send_fields(OP_LIMIT, SIDE_SELL, 16'd200, 32'd2, 32'd21);
    send_fields(OP_MARKET, SIDE_BUY, 16'd0, 32'd3, 32'd22);
    send_fields(OP_CANCEL, SIDE_BUY, 16'd0, 32'd0, 32'd21);
    // Fill the bid side past full, then sweep it with one market sell
    for (int i = 0; i <= SIDE_DEPTH; i++)
      send_fields(OP_LIMIT, SIDE_BUY, 16'(i + 1), 32'd1, 32'(100 + i));
    send_fields(OP_MARKET, SIDE_SELL, 16'd0, 32'hFFFF_FFFF, 32'd99);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 120) hold_req = 1;
      if (n == 300) wait_drained();
      send_order(random_order());
    end
    req.valid = 1'b0;

    while (book.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
